>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside of reset.
`define SIA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// The condition must never be true outside of reset.
`define SIA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define SIA_ASSERT(lbl, clk, rst_n, prop)
`define SIA_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> hw/rtl/sia_pkg.sv
// ----------------------------------------------------------------------------
// Slot index allocator package
// Pool size, derived widths, request and status codes and the state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sia_pkg;

	// Pool size and derived widths.
	localparam int SLOTS = 256;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = IDX_W + 1;

	// Request kinds.
	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NEVER = 2'd2,
		ST_FREE  = 2'd3
	} status_t;

	// Control sequence: wait for a request, then update from the memory reads.
	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

endpackage

`default_nettype wire

>>> hw/rtl/sia_ram.sv
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/slot_index_allocator.sv
// Sequence: a request is accepted in the idle state, where the accept edge reads the
// free stack and the in-use marks; the exec state then updates state and the result.
// Flow: a new request is not accepted until the previous one has left the exec state,
// set by the read-then-write pass through the memories; a waiting result stalls only the update.
// Reset: counters and control clear at once; the memories are not cleared,
// since an in-use mark is only consulted for slots below the bump counter.
// ----------------------------------------------------------------------------
// Slot index allocator
// Grants slot numbers from a free stack or a bump counter and takes them back,
// tracking in-use marks and the live count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module slot_index_allocator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      mode,
	input  wire logic [sia_pkg::IDX_W-1:0] slot,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [sia_pkg::IDX_W-1:0] slot_out,
	output logic      [1:0]                status,
	output logic      [sia_pkg::CNT_W-1:0] live_count
);

	import sia_pkg::*;

	fsm_t             state_q, state_d;
	logic             req_mode_q;
	logic [IDX_W-1:0] req_slot_q;
	logic [CNT_W-1:0] free_top_q, next_fresh_q, live_total_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] slot_out_q;
	status_t          status_q;
	logic [CNT_W-1:0] live_q;

	logic             accept;
	logic             exec_go;

	// Memory ports.
	logic             stk_we;
	logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_rdata;
	logic             mrk_we, mrk_wdata;
	logic [IDX_W-1:0] mrk_waddr;
	logic [0:0]       mrk_rdata;

	// Update results.
	logic [IDX_W-1:0] res_slot;
	status_t          res_status;
	logic [CNT_W-1:0] free_top_d, next_fresh_d, live_total_d;

	assign accept  = in_valid && in_ready;
	assign exec_go = (state_q == FSM_EXEC) && (!out_valid_q || out_ready);

	// The top of the free stack sits one below the fill count.
	assign stk_raddr = IDX_W'(free_top_q - CNT_W'(1));

	sia_ram #(
		.DATA_W(IDX_W),
		.DEPTH (SLOTS)
	) u_free_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(req_slot_q),
		.re   (accept),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	sia_ram #(
		.DATA_W(1),
		.DEPTH (SLOTS)
	) u_in_use (
		.clk  (clk),
		.we   (mrk_we),
		.waddr(mrk_waddr),
		.wdata(mrk_wdata),
		.re   (accept),
		.raddr(slot),
		.rdata(mrk_rdata)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (exec_go) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Capture the request while the memories are read.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_mode_q <= mode;
			req_slot_q <= slot;
		end
	end

	// Decide the outcome from the memory reads and the counters.
	always_comb begin
		res_slot     = req_slot_q;
		res_status   = ST_OK;
		free_top_d   = free_top_q;
		next_fresh_d = next_fresh_q;
		live_total_d = live_total_q;
		stk_we       = 1'b0;
		stk_waddr    = IDX_W'(free_top_q);
		mrk_we       = 1'b0;
		mrk_waddr    = req_slot_q;
		mrk_wdata    = 1'b0;
		if (req_mode_q == MODE_ALLOC) begin
			priority if (free_top_q != '0) begin
				// Reuse the most recently released slot.
				res_slot     = stk_rdata;
				free_top_d   = free_top_q - CNT_W'(1);
				live_total_d = live_total_q + CNT_W'(1);
				mrk_we       = 1'b1;
				mrk_waddr    = stk_rdata;
				mrk_wdata    = 1'b1;
			end else if (next_fresh_q < CNT_W'(SLOTS)) begin
				// Issue a never-used slot.
				res_slot     = IDX_W'(next_fresh_q);
				next_fresh_d = next_fresh_q + CNT_W'(1);
				live_total_d = live_total_q + CNT_W'(1);
				mrk_we       = 1'b1;
				mrk_waddr    = IDX_W'(next_fresh_q);
				mrk_wdata    = 1'b1;
			end else begin
				res_slot   = '0;
				res_status = ST_FULL;
			end
		end else begin
			priority if ({1'b0, req_slot_q} >= next_fresh_q) begin
				res_status = ST_NEVER;
			end else if (!mrk_rdata[0]) begin
				res_status = ST_FREE;
			end else begin
				// Clear the mark and push the slot onto the free stack.
				mrk_we     = 1'b1;
				mrk_wdata  = 1'b0;
				stk_we     = 1'b1;
				free_top_d = free_top_q + CNT_W'(1);
				if (live_total_q != '0) begin
					live_total_d = live_total_q - CNT_W'(1);
				end
			end
		end
		if (!exec_go) begin
			stk_we = 1'b0;
			mrk_we = 1'b0;
		end
	end

	// Counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q   <= '0;
			next_fresh_q <= '0;
			live_total_q <= '0;
		end else if (exec_go) begin
			free_top_q   <= free_top_d;
			next_fresh_q <= next_fresh_d;
			live_total_q <= live_total_d;
		end
	end

	// Output register: holds the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			slot_out_q <= res_slot;
			status_q   <= res_status;
			live_q     <= live_total_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_out   = slot_out_q;
	assign status     = status_q;
	assign live_count = live_q;

	// Every issued slot is either live or on the free stack.
	`SIA_ASSERT(a_pool_balance, clk, arst_n, ({1'b0, free_top_q} + {1'b0, live_total_q}) == {1'b0, next_fresh_q})
	// A granted slot raises the live count by one.
	`SIA_ASSERT(a_alloc_count, clk, arst_n, (exec_go && req_mode_q == MODE_ALLOC && res_status == ST_OK) |=> (live_total_q == $past(live_total_q) + CNT_W'(1)))
	// The memories are never written while a request is being read.
	`SIA_ASSERT_NEVER(a_no_write_on_read, clk, arst_n, accept && (stk_we || mrk_we))

endmodule

`default_nettype wire

>>> sim/grant_checker.sv
// ----------------------------------------------------------------------------
// Slot grant checker
// Watches both channels of the slot index allocator. It keeps its own copy of
// the free stack, the bump counter, the in-use marks and the live count. For
// each accepted request it queues the expected grant, and it compares every
// accepted result, field by field, with the oldest queued grant.
// ----------------------------------------------------------------------------
module grant_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      mode,
	input  logic [sia_pkg::IDX_W-1:0] slot,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [sia_pkg::IDX_W-1:0] slot_out,
	input  logic [1:0]                status,
	input  logic [sia_pkg::CNT_W-1:0] live_count,
	output int                        failures,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import sia_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] slot_out;
		status_t          status;
		logic [CNT_W-1:0] live;
	} grant_t;

	// Shadow allocator state.
	logic [IDX_W-1:0] free_slots [SLOTS];
	bit               held [SLOTS];
	int               stack_depth;
	int               fresh_next;
	int               live;

	grant_t grants_due [$];
	grant_t want;

	// Work out the grant for one request and update the shadow state.
	function automatic grant_t grant_for_request(input logic m, input logic [IDX_W-1:0] s);
		grant_t g;
		g.slot_out = s;
		g.status = ST_OK;
		if (m == MODE_ALLOC) begin
			if (stack_depth > 0) begin
				stack_depth--;
				g.slot_out = free_slots[stack_depth];
			end else if (fresh_next < SLOTS) begin
				g.slot_out = fresh_next[IDX_W-1:0];
				fresh_next++;
			end else begin
				g.slot_out = '0;
				g.status = ST_FULL;
			end
			if (g.status == ST_OK) begin
				held[g.slot_out] = 1'b1;
				live++;
			end
		end else if (int'(s) >= fresh_next) begin
			g.status = ST_NEVER;
		end else if (!held[s]) begin
			g.status = ST_FREE;
		end else begin
			held[s] = 1'b0;
			live--;
			free_slots[stack_depth] = s;
			stack_depth++;
		end
		g.live = live[CNT_W-1:0];
		return g;
	endfunction

	// Predict on accepted requests, compare on accepted results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				held[i] = 1'b0;
				free_slots[i] = '0;
			end
			stack_depth = 0;
			fresh_next = 0;
			live = 0;
			grants_due.delete();
			failures <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				grants_due.push_back(grant_for_request(mode, slot));
			if (out_valid && out_ready) begin
				if (grants_due.size() == 0) begin
					failures <= failures + 1;
					$display("%0t: unexpected result: slot %0d status %0d live %0d",
						$realtime, slot_out, status, live_count);
				end else begin
					want = grants_due.pop_front();
					if (slot_out !== want.slot_out || status !== want.status ||
							live_count !== want.live) begin
						failures <= failures + 1;
						$display("%0t: mismatch: expected slot %0d status %0d live %0d, got slot %0d status %0d live %0d",
							$realtime, want.slot_out, want.status, want.live,
							slot_out, status, live_count);
					end
				end
			end
			pending <= grants_due.size();
		end
	end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Slot index allocator testbench
// Drives allocate and release requests through a directed opening, a random
// phase before the pool is used up, a fill sweep that runs the pool full, and
// random phases of varying allocate share. Both sides idle in random bursts,
// the receiver holds off once for a long stretch, and the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sia_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int LONG_HOLD = 80;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             mode = MODE_ALLOC;
	logic [IDX_W-1:0] slot = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] slot_out;
	logic [1:0]       status;
	logic [CNT_W-1:0] live_count;
	int               failures;
	int               pending;

	// Stimulus controls shared with the receiver process, plus the idle share, allocate count and watchdog counter.
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   stall_left = 0;
	int   idle_pct = 0;
	int   allocs_sent = 0;
	int   quiet_cycles = 0;

	slot_index_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.slot      (slot),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.slot_out  (slot_out),
		.status    (status),
		.live_count(live_count)
	);

	grant_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.slot      (slot),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.slot_out  (slot_out),
		.status    (status),
		.live_count(live_count),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: random stall bursts, one long hold-off, none once calm.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			stall_left <= LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 10) begin
			stall_left <= $urandom_range(1, 12) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one request and wait until it is accepted.
	task automatic send(input logic m, input logic [IDX_W-1:0] s);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		slot <= s;
		do @(posedge clk); while (!in_ready);
		if (m == MODE_ALLOC)
			allocs_sent++;
	endtask

	// Release target: mostly at or below the count of allocate requests sent so far, sometimes anywhere.
	function automatic logic [IDX_W-1:0] pick_slot();
		int hi;
		hi = (allocs_sent > SLOTS - 1) ? SLOTS - 1 : allocs_sent;
		if ($urandom_range(0, 99) < 80)
			return IDX_W'($urandom_range(0, hi));
		return IDX_W'($urandom_range(0, SLOTS - 1));
	endfunction

	// A run of random requests with the given allocate share.
	task automatic run_phase(input int count, input int alloc_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < alloc_pct)
				send(MODE_ALLOC, IDX_W'($urandom));
			else
				send(MODE_RELEASE, pick_slot());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: never issued, LIFO reuse, already free, fresh grants.
		send(MODE_RELEASE, 8'd0);
		send(MODE_RELEASE, 8'd255);
		send(MODE_ALLOC, 8'hFF);
		send(MODE_ALLOC, 8'h00);
		send(MODE_ALLOC, 8'hAA);
		send(MODE_ALLOC, 8'h55);
		send(MODE_RELEASE, 8'd1);
		send(MODE_RELEASE, 8'd1);
		send(MODE_RELEASE, 8'd3);
		send(MODE_ALLOC, 8'd0);
		send(MODE_ALLOC, 8'd0);
		send(MODE_ALLOC, 8'd0);
		send(MODE_RELEASE, 8'd5);
		send(MODE_RELEASE, 8'd4);
		send(MODE_RELEASE, 8'd0);
		send(MODE_RELEASE, 8'd2);
		send(MODE_RELEASE, 8'd0);
		send(MODE_ALLOC, 8'd0);
		send(MODE_ALLOC, 8'd0);
		send(MODE_ALLOC, 8'd0);
		send(MODE_ALLOC, 8'd0);

		// Random mix while the pool is still partly unissued.
		idle_pct = 25;
		run_phase(150, 60);

		// Fill sweep: the pool runs full, with one long hold-off on the receiver.
		idle_pct = 15;
		hold_req <= 1'b1;
		for (int i = 0; i < 270; i++)
			send(MODE_ALLOC, IDX_W'($urandom));

		// Churn with varying allocate share.
		idle_pct = 20;
		run_phase(100, 10);
		idle_pct = 0;
		run_phase(100, 30);
		idle_pct = 30;
		run_phase(100, 50);
		idle_pct = 10;
		run_phase(100, 90);

		// Last part with no idling on either side.
		idle_pct = 0;
		calm <= 1'b1;
		run_phase(100, 50);
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sia_pkg.sv
hw/rtl/sia_ram.sv
hw/rtl/slot_index_allocator.sv
sim/grant_checker.sv
sim/tb_top.sv
